// ----- design/blled_pkg.sv -----
// Shared types and constants for the battery low-level event detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package blled_pkg;

    localparam int CODE_W = 14;
    localparam int CV_W   = 9;
    localparam int MIN_W  = 14;
    localparam int EV_W   = 2;
    localparam int CMP_W  = 11;
    localparam int PROD_W = 21;

    typedef logic [CODE_W-1:0]        t_code;
    typedef logic [CV_W-1:0]          t_cv;
    typedef logic [MIN_W-1:0]         t_min;
    typedef logic [EV_W-1:0]          t_event;
    typedef logic signed [CMP_W-1:0]  t_cmp;

    // (code * 125) >> 12 gives centivolts
    localparam logic [PROD_W-1:0] CV_SCALE = PROD_W'(125);
    localparam int                CV_SHIFT = 12;

    localparam t_cmp BAND_CV       = CMP_W'(20);
    localparam t_min NONE_CV       = MIN_W'(9999);
    localparam t_cv  THR_RESET     = CV_W'(350);
    localparam logic [1:0] QUAL_FIRE = 2'd3;

    localparam t_event EV_NONE  = 2'd0;
    localparam t_event EV_LVL1  = 2'd1;
    localparam t_event EV_LVL2  = 2'd2;
    localparam t_event EV_PSAVE = 2'd3;

endpackage

`default_nettype wire

// ----- design/battery_low_level_event_detector_unit.sv -----
// Battery low-level event detector, top level.
// Depends on blled_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Accepts one 14-bit battery ADC code per cycle, one item per clock, unless
// stalled; returns one result per code: the voltage in centivolts, any
// low-battery event that the reading raises, and the lowest nonzero voltage
// seen since reset. A code passes the input register, then the result
// register; the scaling multiply, band compares and state update are
// combinational between them. The user writes the threshold register through
// i_cfg_we / i_cfg_wdata while no requests are in flight; block does not check.
module battery_low_level_event_detector_unit
    import blled_pkg::*;
(
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_cfg_we,
    input  wire t_cv     i_cfg_wdata,
    input  wire          i_in_valid,
    output logic         o_in_stall,
    input  wire t_code   i_adc_code,
    output logic         o_out_valid,
    input  wire          i_out_stall,
    output t_cv          o_voltage_cv,
    output t_event       o_event_code,
    output t_min         o_min_voltage_cv
);

    t_cv        r_thr;
    logic       r_in_valid;
    t_code      r_code;
    logic       r_out_valid;
    t_cv        r_volt;
    t_event     r_event;
    t_min       r_min_out;

    t_min       r_min, n_min;
    t_min       r_trig, n_trig;
    logic [1:0] r_qcnt, n_qcnt;
    logic       r_l1_sent, n_l1_sent;
    logic       r_l2_sent, n_l2_sent;
    logic       r_ps_sent, n_ps_sent;
    t_event     n_event;

    logic              out_free;
    logic              adv;
    logic              in_acc;
    logic [PROD_W-1:0] prod;
    t_cv               volt;
    t_cmp              vs;
    t_cmp              thr_s;
    t_cmp              thr_hi;
    t_cmp              thr_lo;
    logic              qualify;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign prod   = PROD_W'(r_code) * CV_SCALE;
    assign volt   = prod[CV_SHIFT +: CV_W];
    assign vs     = t_cmp'({2'b00, volt});
    assign thr_s  = t_cmp'({2'b00, r_thr});
    assign thr_hi = thr_s + BAND_CV;
    assign thr_lo = thr_s - BAND_CV;
    assign qualify = (vs <= thr_hi) && (MIN_W'(volt) < r_trig);

    always_comb begin
        n_min     = r_min;
        n_trig    = r_trig;
        n_qcnt    = r_qcnt;
        n_l1_sent = r_l1_sent;
        n_l2_sent = r_l2_sent;
        n_ps_sent = r_ps_sent;
        n_event   = EV_NONE;

        if (volt != '0 && MIN_W'(volt) < r_min) begin
            n_min = MIN_W'(volt);
        end

        if (qualify) begin
            if (r_qcnt == QUAL_FIRE) begin
                // bands are checked in order; a sent event raises nothing
                priority if (!r_l1_sent && vs < thr_hi && vs >= thr_s) begin
                    n_event   = EV_LVL1;
                    n_l1_sent = 1'b1;
                end else if (!r_l2_sent && vs < thr_s && vs > thr_lo) begin
                    n_event   = EV_LVL2;
                    n_l2_sent = 1'b1;
                end else if (!r_ps_sent && vs < thr_lo) begin
                    n_event   = EV_PSAVE;
                    n_ps_sent = 1'b1;
                end else begin
                    // outside every band, or its event already sent
                    n_event = EV_NONE;
                end
                n_qcnt = '0;
                n_trig = MIN_W'(volt);
            end else begin
                n_qcnt = r_qcnt + 2'd1;
            end
        end else begin
            n_qcnt = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_min       <= NONE_CV;
            r_trig      <= NONE_CV;
            r_qcnt      <= '0;
            r_l1_sent   <= 1'b0;
            r_l2_sent   <= 1'b0;
            r_ps_sent   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
                r_min       <= n_min;
                r_trig      <= n_trig;
                r_qcnt      <= n_qcnt;
                r_l1_sent   <= n_l1_sent;
                r_l2_sent   <= n_l2_sent;
                r_ps_sent   <= n_ps_sent;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: load on accept / advance, hold otherwise
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_code <= i_adc_code;
        end
        if (adv) begin
            r_volt    <= volt;
            r_event   <= n_event;
            r_min_out <= n_min;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_voltage_cv     = r_volt;
    assign o_event_code     = r_event;
    assign o_min_voltage_cv = r_min_out;

    a_fire_on_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_event != EV_NONE) |-> (r_qcnt == QUAL_FIRE && qualify))
        else $error("event raised without four qualifying readings");

    a_lvl1_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && n_event == EV_LVL1) |=> (r_l1_sent && !$past(r_l1_sent)))
        else $error("level1 event raised twice");

    a_min_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_min_voltage_cv != '0))
        else $error("minimum voltage reported as zero");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with no request held");

endmodule

`default_nettype wire
